[src/hsl2rgb_pkg.sv]
// Package for the HSL to RGB converter: fixed-point format, ramp constants and
// payload types. No dependencies; used by the channel interfaces and the core.
package hsl2rgb_pkg;

  // Fixed-point format: hue is Q0.FRAC_BITS, channels are unsigned Q1.FRAC_BITS
  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned HUE_W     = FRAC_BITS;
  localparam int unsigned CH_W      = FRAC_BITS + 1;
  localparam int unsigned PROD_W    = 2 * CH_W + 1;  // l * (ONE + s)
  localparam int unsigned RAMP_W    = 2 * CH_W;      // (q - p) * ramp factor
  localparam int unsigned SIX_W     = FRAC_BITS + 3; // 6 * hue

  localparam int unsigned ONE_I        = 1 << FRAC_BITS;
  localparam int unsigned THIRD_I      = (ONE_I + 1) / 3;
  localparam int unsigned TWO_THIRDS_I = (2 * ONE_I + 1) / 3;
  localparam int unsigned SIXTH_I      = (ONE_I + 3) / 6;

  localparam logic [CH_W-1:0]  ONE        = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CH_W-1:0]  HALF       = ONE >> 1;
  localparam logic [HUE_W-1:0] THIRD      = HUE_W'(THIRD_I);
  localparam logic [HUE_W-1:0] TWO_THIRDS = HUE_W'(TWO_THIRDS_I);
  localparam logic [HUE_W-1:0] SIXTH      = HUE_W'(SIXTH_I);

  typedef logic [HUE_W-1:0] hue_t;
  typedef logic [CH_W-1:0]  chan_t;

  // Segment of the hue ramp: rise, plateau at q, fall, floor at p
  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_HIGH = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } seg_e;

endpackage

[src/hsl2rgb_hsl_if.sv]
// Request channel carrying one HSL pixel (valid/ready handshake).
// Depends on hsl2rgb_pkg for the payload types.
interface hsl2rgb_hsl_if;
  logic               valid;
  logic               ready;
  hsl2rgb_pkg::hue_t  hue;
  hsl2rgb_pkg::chan_t saturation;
  hsl2rgb_pkg::chan_t lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

[src/hsl2rgb_rgb_if.sv]
// Request channel carrying one RGB pixel (valid/ready handshake).
// Depends on hsl2rgb_pkg for the payload types.
interface hsl2rgb_rgb_if;
  logic               valid;
  logic               ready;
  hsl2rgb_pkg::chan_t red;
  hsl2rgb_pkg::chan_t green;
  hsl2rgb_pkg::chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[src/hsl_to_rgb_converter_core.sv]
// HSL to RGB pixel converter. Takes one pixel request per clock while the output
// is not stalled and returns one RGB request per pixel, in order. The datapath
// is a five-register pipeline (input conditioning, q/p product, q/p clamp,
// three ramp products, channel select) with one 16x17 multiplier stage and
// three 16x16 multipliers; a stall on the output freezes the whole pipeline,
// and the output register lets a new pixel enter whenever the result register
// is empty or being taken. Zero saturation needs no special path: q and p both
// equal lightness, so all channels do too.
// Depends on hsl2rgb_pkg, hsl2rgb_hsl_if and hsl2rgb_rgb_if.
module hsl_to_rgb_converter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsl2rgb_hsl_if.sink   hsl_i,
  hsl2rgb_rgb_if.source rgb_o
);
  import hsl2rgb_pkg::*;

  // 6 * x as shift and add
  function automatic logic [SIX_W-1:0] six_times(input logic [HUE_W-1:0] x);
    logic [SIX_W-1:0] xe;
    xe = SIX_W'(x);
    return (xe << 2) + (xe << 1);
  endfunction

  // Valid bits: [0..3] pipeline stages, [4] output register
  logic [4:0] vld_q;
  logic       adv;

  // Stage 0 combinational
  chan_t sat_d, lit_d;
  hue_t  t_d [3];

  // Stage 1 registers and logic
  chan_t              sat1_q, lit1_q;
  hue_t               t1_q [3];
  logic               lo_half_d;
  logic [CH_W:0]      mcand_d;
  logic [PROD_W-1:0]  prod_d;
  seg_e               seg_d [3];
  chan_t              fac_d [3];
  logic [SIX_W-1:0]   six_rise [3];
  logic [SIX_W-1:0]   six_fall [3];

  // Stage 2 registers and logic
  logic [PROD_W-1:0]  prod2_q;
  logic               lo_half2_q;
  chan_t              sat2_q, lit2_q;
  seg_e               seg2_q [3];
  chan_t              fac2_q [3];
  logic [PROD_W:0]    qsum;
  chan_t              qrnd;
  logic [CH_W:0]      q_raw;
  chan_t              q_d, p_d, d_d;
  logic signed [CH_W+1:0] p_raw;

  // Stage 3 registers and logic
  chan_t              q3_q, p3_q, d3_q;
  seg_e               seg3_q [3];
  chan_t              fac3_q [3];
  logic [RAMP_W-1:0]  ramp_d [3];

  // Stage 4 registers and logic
  chan_t              q4_q, p4_q;
  seg_e               seg4_q [3];
  logic [RAMP_W-1:0]  ramp4_q [3];
  logic [RAMP_W:0]    rsum [3];
  logic [CH_W:0]      v_raw [3];
  chan_t              chan_d [3];

  // Output registers
  chan_t              red_q, green_q, blue_q;

  // Advance every stage together unless the result register is held
  assign adv         = !vld_q[4] || rgb_o.ready;
  assign hsl_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[3:0], hsl_i.valid};
    end
  end

  // Stage 0: saturate inputs, form the three hue arguments (wrap by width)
  always_comb begin
    sat_d  = (hsl_i.saturation > ONE) ? ONE : hsl_i.saturation;
    lit_d  = (hsl_i.lightness > ONE) ? ONE : hsl_i.lightness;
    t_d[0] = hsl_i.hue + THIRD;
    t_d[1] = hsl_i.hue;
    t_d[2] = hsl_i.hue - THIRD;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sat1_q <= sat_d;
      lit1_q <= lit_d;
      t1_q   <= t_d;
    end
  end

  // Stage 1: product for q, ramp segment and factor per channel
  always_comb begin
    lo_half_d = lit1_q < HALF;
    mcand_d   = lo_half_d ? ({1'b0, ONE} + {1'b0, sat1_q}) : {1'b0, sat1_q};
    prod_d    = PROD_W'(lit1_q) * PROD_W'(mcand_d);
    for (int c = 0; c < 3; c++) begin
      six_rise[c] = six_times(t1_q[c]);
      six_fall[c] = six_times(TWO_THIRDS - t1_q[c]);
      if (t1_q[c] < SIXTH) begin
        seg_d[c] = SEG_RISE;
        fac_d[c] = six_rise[c][CH_W-1:0];
      end else if ({1'b0, t1_q[c]} < HALF) begin
        seg_d[c] = SEG_HIGH;
        fac_d[c] = '0;
      end else if (t1_q[c] < TWO_THIRDS) begin
        seg_d[c] = SEG_FALL;
        fac_d[c] = six_fall[c][CH_W-1:0];
      end else begin
        seg_d[c] = SEG_LOW;
        fac_d[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod2_q    <= prod_d;
      lo_half2_q <= lo_half_d;
      sat2_q     <= sat1_q;
      lit2_q     <= lit1_q;
      seg2_q     <= seg_d;
      fac2_q     <= fac_d;
    end
  end

  // Stage 2: round the product, clamp q to one and p to [0, q]
  always_comb begin
    qsum  = {1'b0, prod2_q} + (PROD_W + 1)'(HALF);
    qrnd  = qsum[FRAC_BITS +: CH_W];
    q_raw = lo_half2_q ? {1'b0, qrnd}
                       : ({1'b0, lit2_q} + {1'b0, sat2_q} - {1'b0, qrnd});
    q_d   = (q_raw > {1'b0, ONE}) ? ONE : q_raw[CH_W-1:0];
    p_raw = $signed({1'b0, lit2_q, 1'b0}) - $signed({2'b00, q_d});
    if (p_raw < 0) begin
      p_d = '0;
    end else if (p_raw > $signed({2'b00, q_d})) begin
      p_d = q_d;
    end else begin
      p_d = p_raw[CH_W-1:0];
    end
    d_d = q_d - p_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q3_q   <= q_d;
      p3_q   <= p_d;
      d3_q   <= d_d;
      seg3_q <= seg2_q;
      fac3_q <= fac2_q;
    end
  end

  // Stage 3: ramp products (q - p) * factor
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ramp_d[c] = RAMP_W'(d3_q) * RAMP_W'(fac3_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q4_q    <= q3_q;
      p4_q    <= p3_q;
      seg4_q  <= seg3_q;
      ramp4_q <= ramp_d;
    end
  end

  // Stage 4: round ramp, select by segment, saturate to one
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rsum[c] = {1'b0, ramp4_q[c]} + (RAMP_W + 1)'(HALF);
      case (seg4_q[c])
        SEG_RISE, SEG_FALL: v_raw[c] = {1'b0, p4_q} + {1'b0, rsum[c][FRAC_BITS +: CH_W]};
        SEG_HIGH:           v_raw[c] = {1'b0, q4_q};
        SEG_LOW:            v_raw[c] = {1'b0, p4_q};
        default:            v_raw[c] = {1'b0, p4_q};
      endcase
      chan_d[c] = (v_raw[c] > {1'b0, ONE}) ? ONE : v_raw[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= chan_d[0];
      green_q <= chan_d[1];
      blue_q  <= chan_d[2];
    end
  end

  assign rgb_o.valid = vld_q[4];
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

`ifndef SYNTH
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (red_q <= ONE && green_q <= ONE && blue_q <= ONE))
    else $error("channel above one on output");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && !rgb_o.ready) |-> !hsl_i.ready)
    else $error("input taken while output is held");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsl_i.valid && hsl_i.ready) |=> vld_q[0])
    else $error("accepted pixel did not enter stage one");

  a_qp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (p3_q <= q3_q && q3_q <= ONE))
    else $error("p above q or q above one");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for hsl_to_rgb_converter_core: random and corner HSL pixels,
// an in-bench fixed-point predictor, and in-order checks of every RGB request.
// Depends on hsl2rgb_pkg, hsl2rgb_hsl_if, hsl2rgb_rgb_if and the core RTL.
module testbench;
  import hsl2rgb_pkg::*;

  localparam int unsigned STUCK_LIMIT  = 5000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned HUE_MASK     = ONE_I - 1;

  typedef struct packed {
    hue_t  hue;
    chan_t saturation;
    chan_t lightness;
  } hsl_pixel_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_pixel_t;

  logic clk_i;
  logic rst_ni;

  hsl2rgb_hsl_if hsl_if ();
  hsl2rgb_rgb_if rgb_if ();

  hsl_to_rgb_converter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsl_i  (hsl_if),
    .rgb_o  (rgb_if)
  );

  hsl_pixel_t  pixel_queue[$];
  rgb_pixel_t  rgb_expected[$];
  hsl_pixel_t  offered_px;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_requests;
  int unsigned holds_done;
  int unsigned hold_left;
  int unsigned stuck_cycles;
  int unsigned mismatches;

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Divide by one with round-half-up
  function automatic longint unsigned round_q(longint unsigned x);
    return (x + (ONE_I >> 1)) >> FRAC_BITS;
  endfunction

  function automatic longint unsigned clamp_one(longint unsigned x);
    return (x > ONE_I) ? longint'(ONE_I) : x;
  endfunction

  // Piecewise hue ramp: rise, plateau at q, fall, floor at p
  function automatic chan_t ramp_level(longint unsigned p, longint unsigned q,
                                       longint unsigned t);
    longint unsigned d;
    longint unsigned v;
    d = q - p;
    if (t < SIXTH_I) begin
      v = p + round_q(d * 6 * t);
    end else if (t < (ONE_I >> 1)) begin
      v = q;
    end else if (t < TWO_THIRDS_I) begin
      v = p + round_q(d * (TWO_THIRDS_I - t) * 6);
    end else begin
      v = p;
    end
    return chan_t'(clamp_one(v));
  endfunction

  // Expected RGB pixel for one HSL pixel
  function automatic rgb_pixel_t convert_pixel(hue_t hue, chan_t sat_in, chan_t light_in);
    longint unsigned h;
    longint unsigned s;
    longint unsigned l;
    longint unsigned q;
    longint unsigned p;
    longint          qs;
    longint          ps;
    rgb_pixel_t      res;
    h = hue;
    s = clamp_one(sat_in);
    l = clamp_one(light_in);
    if (s == 0) begin
      res.red   = chan_t'(l);
      res.green = chan_t'(l);
      res.blue  = chan_t'(l);
    end else begin
      if (l < (ONE_I >> 1)) begin
        qs = longint'(round_q(l * (ONE_I + s)));
      end else begin
        qs = longint'(l + s) - longint'(round_q(l * s));
      end
      if (qs < 0) qs = 0;
      if (qs > longint'(ONE_I)) qs = longint'(ONE_I);
      ps = 2 * longint'(l) - qs;
      if (ps < 0) ps = 0;
      if (ps > qs) ps = qs;
      q = longint'(qs);
      p = longint'(ps);
      res.red   = ramp_level(p, q, (h + THIRD_I) & HUE_MASK);
      res.green = ramp_level(p, q, h);
      res.blue  = ramp_level(p, q, (h + ONE_I - THIRD_I) & HUE_MASK);
    end
    return res;
  endfunction

  task automatic queue_pixel(hue_t hue, chan_t sat, chan_t light);
    hsl_pixel_t px;
    px = {hue, sat, light};
    pixel_queue = {pixel_queue, px};
  endtask

  // Channel value: mostly in range, with zero, one and over-range codes mixed in
  function automatic chan_t random_level();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 10) return ONE;
    if (pick < 18) return chan_t'($urandom_range(ONE_I + 1, 65535));
    return chan_t'($urandom_range(1, ONE_I - 1));
  endfunction

  task automatic queue_random(int unsigned count);
    repeat (count) begin
      queue_pixel(hue_t'($urandom_range(0, ONE_I - 1)), random_level(), random_level());
    end
  endtask

  // Hold until every queued pixel went in and every result came back
  task automatic wait_drained();
    while (pixel_queue.size() != 0 || hsl_if.valid || rgb_expected.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Drive HSL requests and predict each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsl_if.valid      <= 1'b0;
      hsl_if.hue        <= '0;
      hsl_if.saturation <= '0;
      hsl_if.lightness  <= '0;
    end else begin
      if (hsl_if.valid && hsl_if.ready) begin
        rgb_expected = {rgb_expected, convert_pixel(hsl_if.hue, hsl_if.saturation,
                                                    hsl_if.lightness)};
      end
      if (!hsl_if.valid || hsl_if.ready) begin
        if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered_px         = pixel_queue.pop_front();
          hsl_if.valid      <= 1'b1;
          hsl_if.hue        <= offered_px.hue;
          hsl_if.saturation <= offered_px.saturation;
          hsl_if.lightness  <= offered_px.lightness;
        end else begin
          hsl_if.valid <= 1'b0;
        end
      end
    end
  end

  // Count out a long receiver hold-off when one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_done) begin
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end
  end

  // Drive RGB ready with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_if.ready <= 1'b0;
    end else begin
      rgb_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check each accepted RGB request against the oldest prediction
  always @(posedge clk_i) begin
    rgb_pixel_t want;
    if (rst_ni && rgb_if.valid && rgb_if.ready) begin
      if (rgb_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected RGB request: r=%0d g=%0d b=%0d",
                   rgb_if.red, rgb_if.green, rgb_if.blue);
        end
      end else begin
        want = rgb_expected.pop_front();
        if (rgb_if.red !== want.red || rgb_if.green !== want.green ||
            rgb_if.blue !== want.blue) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("RGB mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue,
                     rgb_if.red, rgb_if.green, rgb_if.blue);
          end
        end
      end
    end
  end

  // End the run if work is pending and nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (hsl_if.valid && hsl_if.ready) || (rgb_if.valid && rgb_if.ready)) begin
      stuck_cycles <= 0;
    end else if (pixel_queue.size() != 0 || hsl_if.valid || rgb_expected.size() != 0) begin
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst_ni            = 1'b0;
    hold_requests     = 0;
    send_idle_pct     = 25;
    recv_idle_pct     = 80;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Corners: ramp segment edges, hue wrap, zero and over-range levels
    queue_pixel(hue_t'(0), 16'd0, 16'd0);
    queue_pixel(hue_t'(HUE_MASK), ONE, ONE);
    queue_pixel(hue_t'(0), ONE, HALF);
    queue_pixel(SIXTH - 1'b1, ONE, HALF);
    queue_pixel(SIXTH, ONE, HALF);
    queue_pixel(hue_t'(HALF - 1'b1), ONE, HALF);
    queue_pixel(hue_t'(HALF), ONE, HALF);
    queue_pixel(TWO_THIRDS - 1'b1, ONE, HALF);
    queue_pixel(TWO_THIRDS, ONE, HALF);
    queue_pixel(hue_t'(ONE_I - THIRD_I - 1), ONE, HALF);
    queue_pixel(hue_t'(ONE_I - THIRD_I), ONE, HALF);
    queue_pixel(THIRD, 16'hFFFF, 16'hFFFF);
    queue_pixel(hue_t'(12345), 16'd0, 16'd20000);
    queue_pixel(hue_t'(12345), 16'd0, 16'hFFFF);
    queue_pixel(hue_t'(5000), 16'd20000, HALF - 1'b1);
    queue_pixel(hue_t'(5000), 16'd20000, HALF);
    queue_pixel(hue_t'(20000), 16'h8001, 16'd100);
    queue_pixel(hue_t'(30000), 16'd1, ONE);
    queue_pixel(hue_t'(7000), ONE, 16'd1);
    queue_pixel(hue_t'(1000), 16'h7FFF, 16'h7FFF);
    queue_pixel(hue_t'(26000), 16'h5555, 16'hAAAA);

    // Sender idles lightly, receiver heavily; pause the sender midway
    queue_random(75);
    wait_drained();
    queue_random(75);
    wait_drained();

    // Swap the idling
    send_idle_pct = 80;
    recv_idle_pct = 25;
    queue_random(150);
    wait_drained();

    // Full rate, with one long receiver hold-off while requests keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(60);
    hold_requests = hold_requests + 1;
    queue_random(140);
    wait_drained();

    // Catch any late or extra results
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
